/* rtl/shc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_pkg: shared types and constants for the strip hit clusterer
// Holds the channel payload structs, the controller/datapath command and
// status structs and the default sizes.
// ----------------------------------------------------------------------------
package shc_pkg;

    localparam int MAX_HITS_DEF   = 64;
    localparam int STRIP_BITS_DEF = 10;
    localparam int STRIP_W        = 10;
    localparam int MULT_W         = 7;

    typedef struct packed {
        logic [STRIP_W-1:0] strip;
        logic               last;
    } shc_hit_t;

    typedef struct packed {
        logic [STRIP_W-1:0] center;
        logic [MULT_W-1:0]  multiplicity;
        logic               final_cluster;
        logic               overflow;
    } shc_cluster_t;

    // controller -> datapath
    typedef struct packed {
        logic insert;      // insert the incoming hit into the sorted store
        logic drop;        // store full: drop the hit, mark the set
        logic pop;         // shift the lowest hit out into the run tracker
        logic emit;        // load the output register with the open cluster
        logic emit_final;  // the emitted cluster closes the set
        logic clear;       // end of set: empty store and flags
    } shc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;        // store holds MAX_HITS hits
        logic empty;       // no hits left in the store
        logic started;     // a run is open
        logic brk;         // lowest stored hit does not extend the open run
        logic slot_free;   // output register can take a cluster this cycle
    } shc_stat_t;

endpackage

/* rtl/strip_hit_clusterer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_hit_clusterer: adjacent strip clustering for one detector layer
//
// Hit channel (hit_valid / hit_stall / hit): one strip number per transfer,
// hit.last closes the set. Hits are taken one per cycle while a set loads;
// each is inserted straight into a sorted row of MAX_HITS cells. Hits past
// MAX_HITS are dropped and every cluster of that set carries overflow.
// After the last hit, hit_stall stays high while the set drains: the row
// shifts down one hit per cycle, unless held, into a run tracker, and each
// broken run becomes one transfer on the cluster channel (clu_valid /
// clu_stall / cluster), in ascending strip order, final_cluster on the last
// one. A broken run or the final cluster that meets a full, stalled output
// register holds the drain until the register can take it.
// The output register lets a finished cluster wait while the next set
// loads. Reset clears the controller, fill count and output valid; the
// stored strips themselves are not cleared.
// ----------------------------------------------------------------------------
module strip_hit_clusterer
    import shc_pkg::*;
#(
    parameter int MAX_HITS   = MAX_HITS_DEF,
    parameter int STRIP_BITS = STRIP_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         hit_valid,
    output logic         hit_stall,
    input  shc_hit_t     hit,
    output logic         clu_valid,
    input  logic         clu_stall,
    output shc_cluster_t cluster
);

    shc_cmd_t  cmd;
    shc_stat_t stat;

    // sequencing: load, drain, final cluster
    shc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_valid),
        .hit_last  (hit.last),
        .hit_stall (hit_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // sorted store, run tracker and output register
    shc_datapath #(
        .MAX_HITS   (MAX_HITS),
        .STRIP_BITS (STRIP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit       (hit),
        .cmd       (cmd),
        .stat      (stat),
        .clu_valid (clu_valid),
        .clu_stall (clu_stall),
        .cluster   (cluster)
    );

endmodule

/* rtl/shc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_datapath: sorted hit store, run tracker and output register
// Hits are inserted into a row of sorted cells; draining shifts it down one
// cell a cycle, unless a stalled output holds it, past the cluster run tracker.
// ----------------------------------------------------------------------------
module shc_datapath
    import shc_pkg::*;
#(
    parameter int MAX_HITS   = MAX_HITS_DEF,
    parameter int STRIP_BITS = STRIP_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  shc_hit_t     hit,
    input  shc_cmd_t     cmd,
    output shc_stat_t    stat,
    output logic         clu_valid,
    input  logic         clu_stall,
    output shc_cluster_t cluster
);

    localparam int CW = $clog2(MAX_HITS + 1);
    localparam int SB = STRIP_BITS;

    logic [SB-1:0] store_reg [MAX_HITS];
    logic [SB-1:0] store_next [MAX_HITS];
    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic          started_reg;
    logic [SB-1:0] first_reg;
    logic [SB-1:0] prev_reg;
    logic [CW-1:0] mult_reg;
    logic          out_valid_reg;
    shc_cluster_t  out_data_reg;

    logic [SB+STRIP_W-1:0] strip_wide;
    logic [SB-1:0]         hit_val;
    logic [MAX_HITS-1:0]   occ;
    logic [MAX_HITS-1:0]   gt;
    logic [SB-1:0]         cur;
    logic [SB:0]           sum;
    logic [SB+STRIP_W-1:0] center_wide;
    logic [CW+MULT_W-1:0]  mult_wide;
    logic                  slot_free;

    // keep only the low STRIP_BITS bits of the strip number
    assign strip_wide = {{SB{1'b0}}, hit.strip};
    assign hit_val    = strip_wide[SB-1:0];
    assign cur        = store_reg[0];

    always_comb
    begin
        for (int i = 0; i < MAX_HITS; i++)
        begin
            occ[i] = CW'(i) < count_reg;
            gt[i]  = occ[i] && (store_reg[i] > hit_val);
        end
    end

    // each cell: insert (shift up past the new value) or drain (shift down)
    always_comb
    begin
        for (int i = 0; i < MAX_HITS; i++)
        begin
            store_next[i] = store_reg[i];
            if (cmd.insert)
            begin
                if (gt[i] || (CW'(i) == count_reg))
                begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                        store_next[i] = store_reg[(i > 0) ? i - 1 : 0];
                    else
                        store_next[i] = hit_val;
                end
            end
            else if (cmd.pop && i < MAX_HITS - 1)
            begin
                store_next[i] = store_reg[(i < MAX_HITS - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_HITS; i++)
            store_reg[i] <= store_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
                count_reg <= count_reg + CW'(1);
            else if (cmd.pop)
                count_reg <= count_reg - CW'(1);
            if (cmd.drop)
                dropped_reg <= 1'b1;
            if (cmd.pop)
                started_reg <= 1'b1;
        end
    end

    // run tracker
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            if (!started_reg || stat.brk)
            begin
                first_reg <= cur;
                mult_reg  <= CW'(1);
            end
            else
            begin
                mult_reg <= mult_reg + CW'(1);
            end
            prev_reg <= cur;
        end
    end

    assign sum         = {1'b0, first_reg} + {1'b0, prev_reg};
    assign center_wide = {{STRIP_W{1'b0}}, sum[SB:1]};
    assign mult_wide   = {{MULT_W{1'b0}}, mult_reg};

    // output register
    assign slot_free = !out_valid_reg || !clu_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!clu_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.center        <= center_wide[STRIP_W-1:0];
            out_data_reg.multiplicity  <= mult_wide[MULT_W-1:0];
            out_data_reg.final_cluster <= cmd.emit_final;
            out_data_reg.overflow      <= dropped_reg;
        end
    end

    assign stat.full      = count_reg == CW'(MAX_HITS);
    assign stat.empty     = count_reg == '0;
    assign stat.started   = started_reg;
    assign stat.brk       = {1'b0, cur} != ({1'b0, prev_reg} + (SB+1)'(1));
    assign stat.slot_free = slot_free;

    assign clu_valid = out_valid_reg;
    assign cluster   = out_data_reg;

endmodule

/* rtl/shc_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_controller: set sequencing for the strip hit clusterer
// Loads hits until the last flag, drains the sorted store into clusters,
// then emits the final cluster and clears for the next set.
// ----------------------------------------------------------------------------
module shc_controller
    import shc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hit_valid,
    input  logic      hit_last,
    output logic      hit_stall,
    input  shc_stat_t stat,
    output shc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_FLUSH = 3'b100
    } shc_state_t;

    shc_state_t state_reg;
    shc_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (hit_valid)
                begin
                    cmd.insert = !stat.full;
                    cmd.drop   = stat.full;
                    if (hit_last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.empty)
                    state_next = ST_FLUSH;
                else if (stat.started && stat.brk)
                begin
                    // run broken: hand the open cluster over, then advance
                    if (stat.slot_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.pop  = 1'b1;
                    end
                end
                else
                    cmd.pop = 1'b1;
            end
            ST_FLUSH:
            begin
                if (!stat.started)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
                else if (stat.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_final = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    assign hit_stall = state_reg != ST_LOAD;

endmodule

/* rtl/shc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_checker: port-level checks for the strip hit clusterer
// Watches both channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module shc_checker
    import shc_pkg::*;
#(
    parameter int MAX_HITS = MAX_HITS_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         hit_valid,
    input logic         hit_stall,
    input shc_hit_t     hit,
    input logic         clu_valid,
    input logic         clu_stall,
    input shc_cluster_t cluster
);

    // hold a stalled cluster unchanged
    a_clu_hold: assert property (@(posedge clk) disable iff (!rst_n)
        clu_valid && clu_stall |=> clu_valid && $stable(cluster))
        else $error("cluster changed while stalled");

    // a closing hit stops further hits while the set drains
    a_drain_stall: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_stall && hit.last |=> hit_stall)
        else $error("hit taken straight after end of set");

    a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
        clu_valid |-> cluster.multiplicity != '0 &&
                      cluster.multiplicity <= MULT_W'(MAX_HITS))
        else $error("cluster multiplicity out of range");

    // a new cluster that appears mid-drain was loaded while hit_stall was high
    a_no_load_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(clu_valid) && !cluster.final_cluster |-> $past(hit_stall))
        else $error("cluster emitted outside drain");

endmodule

bind strip_hit_clusterer shc_checker #(
    .MAX_HITS (MAX_HITS)
) u_shc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit_valid (hit_valid),
    .hit_stall (hit_stall),
    .hit       (hit),
    .clu_valid (clu_valid),
    .clu_stall (clu_stall),
    .cluster   (cluster)
);

/* sim/strip_hit_clusterer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_hit_clusterer_tb: self-checking bench for the strip hit clusterer
// Feeds sets of strip hits on the hit channel and checks every cluster
// against a software clustering of the same set. It opens with hand-picked
// sets covering edges, duplicates and gaps. Random sets follow, most of them
// small and dense so that runs form often, with some full and overflowing
// sets. Idling moves from the receiver to the sender and then stops.
// ----------------------------------------------------------------------------
module strip_hit_clusterer_tb;
    import shc_pkg::*;

    localparam int N_HITS     = MAX_HITS_DEF;
    localparam int STRIP_MAX  = (1 << STRIP_BITS_DEF) - 1;
    localparam int RAND_ITEMS = 330;

    // ------------------------------------------------------------------------
    // Clustering predictor: mirrors the store of one set and queues the
    // clusters that set must produce.
    // ------------------------------------------------------------------------
    class cluster_predictor;
        logic [STRIP_W-1:0] layer_hits[$];
        bit                 hits_dropped;
        shc_cluster_t       expected_clusters[$];
        int                 errors;

        function void add_cluster(int lo, int hi, int mult, bit closes);
            shc_cluster_t c;
            c.center        = STRIP_W'((lo + hi) >> 1);
            c.multiplicity  = MULT_W'(mult);
            c.final_cluster = closes;
            c.overflow      = hits_dropped;
            expected_clusters = {expected_clusters, c};
        endfunction

        function void note_hit(shc_hit_t h);
            logic [STRIP_W-1:0] v;
            int i, j, lo, prev, cur, mult;
            if (layer_hits.size() < N_HITS)
                layer_hits = {layer_hits, h.strip & STRIP_W'(STRIP_MAX)};
            else
                hits_dropped = 1'b1;
            if (!h.last)
                return;
            // sort ascending, then split into runs of consecutive strips
            for (i = 1; i < layer_hits.size(); i++)
            begin
                v = layer_hits[i];
                j = i;
                while (j > 0 && layer_hits[j-1] > v)
                begin
                    layer_hits[j] = layer_hits[j-1];
                    j--;
                end
                layer_hits[j] = v;
            end
            if (layer_hits.size() > 0)
            begin
                lo   = layer_hits[0];
                prev = lo;
                mult = 1;
                for (i = 1; i < layer_hits.size(); i++)
                begin
                    cur = layer_hits[i];
                    if (cur == prev + 1)
                        mult++;
                    else
                    begin
                        add_cluster(lo, prev, mult, 1'b0);
                        lo   = cur;
                        mult = 1;
                    end
                    prev = cur;
                end
                add_cluster(lo, prev, mult, 1'b1);
            end
            layer_hits.delete();
            hits_dropped = 1'b0;
        endfunction

        function void check_cluster(shc_cluster_t got);
            shc_cluster_t want;
            if (expected_clusters.size() == 0)
            begin
                $display("%0t: unexpected cluster, expected none, got center %0d mult %0d",
                         $time, got.center, got.multiplicity);
                errors++;
                return;
            end
            want = expected_clusters.pop_front();
            if (got.center !== want.center)
            begin
                $display("%0t: center expected %0d, got %0d",
                         $time, want.center, got.center);
                errors++;
            end
            if (got.multiplicity !== want.multiplicity)
            begin
                $display("%0t: multiplicity expected %0d, got %0d",
                         $time, want.multiplicity, got.multiplicity);
                errors++;
            end
            if (got.final_cluster !== want.final_cluster)
            begin
                $display("%0t: final_cluster expected %0b, got %0b",
                         $time, want.final_cluster, got.final_cluster);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $display("%0t: overflow expected %0b, got %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         hit_valid = 1'b0;
    logic         hit_stall;
    shc_hit_t     hit       = '0;
    logic         clu_valid;
    logic         clu_stall = 1'b0;
    shc_cluster_t cluster;

    cluster_predictor pred;
    int sender_idle    = 0;   // percent of cycles the sender holds back
    int receiver_stall = 0;   // percent of cycles the receiver stalls
    int hits_sent      = 0;

    always #4 clk = ~clk;

    strip_hit_clusterer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit       (hit),
        .clu_valid (clu_valid),
        .clu_stall (clu_stall),
        .cluster   (cluster)
    );

    // ------------------------------------------------------------------------
    // Hit channel driver
    // ------------------------------------------------------------------------

    // Offer one hit, idling at random first. Outputs are read straight after
    // the edge, so hit_stall still holds the value the edge saw; the transfer
    // happened when it was low.
    task send_hit(input int s, input bit closes);
        shc_hit_t h;
        h.strip = STRIP_W'(s);
        h.last  = closes;
        while ($urandom_range(0, 99) < sender_idle)
        begin
            hit_valid <= 1'b0;
            @(posedge clk);
        end
        hit_valid <= 1'b1;
        hit       <= h;
        do
            @(posedge clk);
        while (hit_stall);
        pred.note_hit(h);
        hits_sent++;
    endtask

    // Send a whole set; the last entry carries the closing flag.
    task send_set(input int strips[$]);
        int i;
        for (i = 0; i < strips.size(); i++)
            send_hit(strips[i], i == strips.size() - 1);
    endtask

    // A set of n hits in a narrow window, so that runs, gaps and duplicates
    // all turn up; some sets sit hard against either end of the strip range,
    // others are spread over the whole range to toggle every strip bit.
    task random_set(input int n);
        int strips[$];
        int i, style, span, base;
        style = $urandom_range(0, 9);
        span  = $urandom_range(n / 2, 2 * n);
        base  = $urandom_range(0, STRIP_MAX - span);
        if (style == 8)
            base = 0;
        else if (style == 9)
            base = STRIP_MAX - span;
        for (i = 0; i < n; i++)
        begin
            if (style == 6 || style == 7)
                strips = {strips, int'($urandom_range(0, STRIP_MAX))};
            else
                strips = {strips, base + int'($urandom_range(0, span))};
        end
        send_set(strips);
    endtask

    // Fill the store with one shuffled block of consecutive strips, which
    // gives the widest possible cluster, then add hits that must be dropped.
    // With extra hits the closing hit is itself a dropped one.
    task full_set(input int extra);
        int strips[$];
        int i, j, tmp, base;
        base = $urandom_range(0, STRIP_MAX - (N_HITS - 1));
        for (i = 0; i < N_HITS; i++)
            strips = {strips, base + i};
        for (i = N_HITS - 1; i > 0; i--)
        begin
            j          = $urandom_range(0, i);
            tmp        = strips[i];
            strips[i]  = strips[j];
            strips[j]  = tmp;
        end
        for (i = 0; i < extra; i++)
            strips = {strips, int'($urandom_range(0, STRIP_MAX))};
        send_set(strips);
    endtask

    // ------------------------------------------------------------------------
    // Cluster channel: check each transfer, then draw the next stall
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && clu_valid && !clu_stall)
                pred.check_cluster(cluster);
            clu_stall <= ($urandom_range(0, 99) < receiver_stall);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        pred = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Receiver stalls more than the sender idles in the first phase.
        sender_idle    = 33;
        receiver_stall = 61;

        // Directed sets: range ends, a run reaching the top strip, a
        // duplicate splitting a run, an odd-sum centre and a gap, widely
        // spread strips and alternating bit patterns.
        send_set('{0});
        send_set('{STRIP_MAX});
        send_set('{STRIP_MAX - 1, STRIP_MAX, STRIP_MAX - 2});
        send_set('{5, 5, 6});
        send_set('{10, 12, 11, 20, 13});
        send_set('{STRIP_MAX, 0, 512, 511});
        send_set('{'h2AA, 'h155});

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase > 0)
            begin
                // Hold the sender until every queued cluster has drained.
                hit_valid <= 1'b0;
                while (pred.expected_clusters.size() != 0)
                    @(posedge clk);
                sender_idle    = (phase == 1) ? 61 : 0;
                receiver_stall = (phase == 1) ? 33 : 0;
            end
            // The first two phases open with a full store: overflowing first, then
            // exactly full.
            if (phase == 0)
                full_set(2);
            else if (phase == 1)
                full_set(0);
            while (hits_sent < RAND_ITEMS * (phase + 1) / 3)
            begin
                if ($urandom_range(0, 24) == 0)
                    full_set($urandom_range(0, 3));
                else
                    random_set($urandom_range(1, 12));
            end
        end

        // Drop valid, let the last clusters drain, then give the block time
        // to show any stray transfer.
        hit_valid <= 1'b0;
        while (pred.expected_clusters.size() != 0)
            @(posedge clk);
        repeat (2 * N_HITS + 20) @(posedge clk);
        if (pred.errors == 0)
            $display("strip_hit_clusterer: match");
        else
            $display("strip_hit_clusterer: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("strip_hit_clusterer: mismatch");
        $finish;
    end

endmodule
